// ===== rtl/swtb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI word transfer bridge package
// Shared constants and types for the mode 3 word transfer bridge.
// ----------------------------------------------------------------------------
package swtb_pkg;

  localparam int unsigned WordBits       = 32;
  localparam int unsigned FifoDepth      = 4;
  localparam logic [7:0]  HalfPeriodRst  = 8'd62;

  typedef struct packed {
    logic clk;
    logic mosi;
    logic done;
  } swtb_pins_t;

  localparam int unsigned PinsBits = $bits(swtb_pins_t);

endpackage

// ===== rtl/swtb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI word transfer bridge step queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module swtb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = swtb_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/swtb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI word transfer bridge front
// Collects host bytes, runs the mode 3 bit timing and emits one step record.
// ----------------------------------------------------------------------------
module swtb_front #(
  parameter int unsigned WORD_BITS = swtb_pkg::WordBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   accept_i,
  input  logic                   op_i,
  input  logic [7:0]             host_byte_i,
  input  logic                   miso_i,
  output swtb_pkg::swtb_pins_t   pins_o,
  output logic [WORD_BITS-1:0]   recv_o
);

  localparam int unsigned WordBytes = (WORD_BITS + 7) / 8;
  localparam int unsigned LaneBits  = WordBytes * 8;
  localparam int unsigned ByteCntW  = $clog2(WordBytes + 1);
  localparam int unsigned BitCntW   = $clog2(WORD_BITS + 1);

  localparam logic [1:0] PhCollect = 2'd0;
  localparam logic [1:0] PhWait    = 2'd1;
  localparam logic [1:0] PhLow     = 2'd2;
  localparam logic [1:0] PhHigh    = 2'd3;

  localparam logic OpHost = 1'b0;

  logic [7:0]           half_period_q;
  logic [1:0]           phase_q, phase_d;
  logic [ByteCntW-1:0]  byte_count_q, byte_count_d;
  logic                 wait_ready_q, wait_ready_d;
  logic [WORD_BITS-1:0] send_word_q, send_word_d;
  logic [WORD_BITS-1:0] recv_word_q, recv_word_d;
  logic [BitCntW-1:0]   bit_count_q, bit_count_d;
  logic [7:0]           tick_count_q, tick_count_d;
  logic                 clk_level_q, clk_level_d;
  logic                 mosi_level_q, mosi_level_d;
  logic                 done;
  logic                 start_low;
  logic [WORD_BITS-1:0] start_src;
  logic [ByteCntW-1:0]  lane_sel;
  logic [LaneBits-1:0]  lane_ins;
  logic [WORD_BITS-1:0] send_or;
  logic                 half_end;

  assign lane_sel = byte_count_q - ByteCntW'(1);
  assign lane_ins = LaneBits'(host_byte_i) << {lane_sel, 3'b000};
  assign send_or  = send_word_q | lane_ins[WORD_BITS-1:0];
  assign half_end = (tick_count_q == half_period_q);

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    wait_ready_d = wait_ready_q;
    send_word_d  = send_word_q;
    recv_word_d  = recv_word_q;
    bit_count_d  = bit_count_q;
    tick_count_d = tick_count_q;
    clk_level_d  = clk_level_q;
    mosi_level_d = mosi_level_q;
    done         = 1'b0;
    start_low    = 1'b0;
    start_src    = send_word_q;
    if (accept_i) begin
      if (op_i == OpHost) begin
        if (phase_q == PhCollect) begin
          if (byte_count_q == '0) begin
            wait_ready_d = ~host_byte_i[0];
            send_word_d  = '0;
            byte_count_d = ByteCntW'(1);
          end else begin
            send_word_d  = send_or;
            byte_count_d = byte_count_q + ByteCntW'(1);
            if (byte_count_q == ByteCntW'(WordBytes)) begin
              byte_count_d = '0;
              recv_word_d  = '0;
              bit_count_d  = '0;
              if (wait_ready_q) begin
                phase_d = PhWait;
              end else begin
                start_low = 1'b1;
                start_src = send_or;
              end
            end
          end
        end
      end else begin
        case (phase_q)
          PhWait: begin
            if (!miso_i) begin
              start_low = 1'b1;
            end
          end
          PhLow: begin
            if (half_end) begin
              clk_level_d  = 1'b1;
              recv_word_d  = {recv_word_q[WORD_BITS-2:0], miso_i};
              tick_count_d = '0;
              phase_d      = PhHigh;
            end else begin
              tick_count_d = tick_count_q + 8'd1;
            end
          end
          PhHigh: begin
            if (half_end) begin
              if (bit_count_q >= BitCntW'(WORD_BITS - 1)) begin
                clk_level_d  = 1'b1;
                mosi_level_d = 1'b1;
                tick_count_d = '0;
                bit_count_d  = '0;
                phase_d      = PhCollect;
                done         = 1'b1;
              end else begin
                bit_count_d = bit_count_q + BitCntW'(1);
                start_low   = 1'b1;
              end
            end else begin
              tick_count_d = tick_count_q + 8'd1;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
    if (start_low) begin
      clk_level_d  = 1'b0;
      mosi_level_d = start_src[WORD_BITS-1];
      send_word_d  = start_src << 1;
      tick_count_d = '0;
      phase_d      = PhLow;
    end
  end

  assign pins_o.clk  = clk_level_d;
  assign pins_o.mosi = mosi_level_d;
  assign pins_o.done = done;
  assign recv_o      = recv_word_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= swtb_pkg::HalfPeriodRst;
      phase_q       <= PhCollect;
      byte_count_q  <= '0;
      wait_ready_q  <= 1'b0;
      send_word_q   <= '0;
      recv_word_q   <= '0;
      bit_count_q   <= '0;
      tick_count_q  <= '0;
      clk_level_q   <= 1'b1;
      mosi_level_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        half_period_q <= cfg_data_i;
      end
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      wait_ready_q <= wait_ready_d;
      send_word_q  <= send_word_d;
      recv_word_q  <= recv_word_d;
      bit_count_q  <= bit_count_d;
      tick_count_q <= tick_count_d;
      clk_level_q  <= clk_level_d;
      mosi_level_q <= mosi_level_d;
    end
  end

endmodule

// ===== rtl/swtb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI word transfer bridge back
// Expands each step record into a pin result and, at transfer end, reply bytes.
// ----------------------------------------------------------------------------
module swtb_back #(
  parameter int unsigned WORD_BITS = swtb_pkg::WordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rec_valid_i,
  input  swtb_pkg::swtb_pins_t rec_pins_i,
  input  logic [WORD_BITS-1:0] rec_recv_i,
  output logic                 rec_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output logic                 kind_o,
  output logic                 clk_res_o,
  output logic                 mosi_o,
  output logic [7:0]           reply_byte_o,
  output logic                 last_o
);

  localparam int unsigned WordBytes = (WORD_BITS + 7) / 8;
  localparam int unsigned LaneBits  = WordBytes * 8;
  localparam int unsigned ByteCntW  = $clog2(WordBytes + 1);

  localparam logic KindPin   = 1'b0;
  localparam logic KindReply = 1'b1;

  logic                 head_valid_q, head_valid_d;
  logic [ByteCntW-1:0]  head_cnt_q, head_cnt_d;
  swtb_pkg::swtb_pins_t head_pins_q;
  logic [LaneBits-1:0]  head_data_q;
  logic                 item_last, take, finish, load;

  assign item_last = (head_cnt_q == '0) ? ~head_pins_q.done
                                        : (head_cnt_q == ByteCntW'(WordBytes));
  assign take      = head_valid_q & pop;
  assign finish    = take & item_last;
  assign load      = rec_valid_i & (~head_valid_q | finish);
  assign rec_pop_o = load;

  assign empty        = ~head_valid_q;
  assign kind_o       = (head_cnt_q == '0) ? KindPin : KindReply;
  assign clk_res_o    = head_pins_q.clk;
  assign mosi_o       = head_pins_q.mosi;
  assign reply_byte_o = (kind_o == KindReply) ? head_data_q[7:0] : 8'd0;
  assign last_o       = item_last;

  always_comb begin
    head_valid_d = head_valid_q;
    head_cnt_d   = head_cnt_q;
    if (load) begin
      head_valid_d = 1'b1;
      head_cnt_d   = '0;
    end else if (finish) begin
      head_valid_d = 1'b0;
      head_cnt_d   = '0;
    end else if (take) begin
      head_cnt_d = head_cnt_q + ByteCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      head_cnt_q   <= '0;
    end else begin
      head_valid_q <= head_valid_d;
      head_cnt_q   <= head_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      head_pins_q <= rec_pins_i;
      head_data_q <= LaneBits'(rec_recv_i);
    end else if (take && (head_cnt_q != '0)) begin
      head_data_q <= head_data_q >> 8;
    end
  end

endmodule

// ===== rtl/spi_word_transfer_bridge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI word transfer bridge
// Mode 3 serial master that sends one host word and returns the reply word.
// ----------------------------------------------------------------------------
// Input queue: push with op_i (0 host byte, 1 timer tick), host_byte_i and
// miso_i; the item transfers when push is high and full is low. One item can
// transfer every clock while full is low.
// Result queue: while empty is low the oldest result sits on kind_o,
// clk_res_o, mosi_o, reply_byte_o and last_o; pop takes it. Every item gives
// one pin result; the tick that ends a word adds one reply byte per word byte,
// least significant first.
// The front part handles each item in the cycle it transfers and queues a
// step record (up to FIFO_DEPTH deep); the pin result passes through the
// record queue and the back part's head register before it shows on the
// result ports. The back part hands out one result per pop, so sustained
// throughput is one item per cycle while pop is held high; the tick that ends
// a word holds the result side while its reply bytes are popped.
// When pop stays low the record queue fills and full rises; nothing is lost.
// Configuration: cfg_valid_i with cfg_data_i writes half_period; cfg_ready_o
// is always high. Reset sets half_period to 62, idles both serial lines high
// and empties all queues.
// ----------------------------------------------------------------------------
module spi_word_transfer_bridge #(
  parameter int unsigned WORD_BITS  = swtb_pkg::WordBits,
  parameter int unsigned FIFO_DEPTH = swtb_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic       op_i,
  input  logic [7:0] host_byte_i,
  input  logic       miso_i,
  output logic       empty,
  input  logic       pop,
  output logic       kind_o,
  output logic       clk_res_o,
  output logic       mosi_o,
  output logic [7:0] reply_byte_o,
  output logic       last_o
);

  localparam int unsigned RecBits = swtb_pkg::PinsBits + WORD_BITS;

  swtb_pkg::swtb_pins_t front_pins, rec_pins;
  logic [WORD_BITS-1:0] front_recv, rec_recv;
  logic [RecBits-1:0]   rec_rdata;
  logic                 accept, rec_valid, rec_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push & ~full;

  swtb_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .op_i       (op_i),
    .host_byte_i(host_byte_i),
    .miso_i     (miso_i),
    .pins_o     (front_pins),
    .recv_o     (front_recv)
  );

  swtb_fifo #(
    .WIDTH(RecBits),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i({front_pins, front_recv}),
    .full_o (full),
    .pop_i  (rec_pop),
    .rdata_o(rec_rdata),
    .valid_o(rec_valid)
  );

  assign rec_pins = rec_rdata[RecBits-1:WORD_BITS];
  assign rec_recv = rec_rdata[WORD_BITS-1:0];

  swtb_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_pins_i  (rec_pins),
    .rec_recv_i  (rec_recv),
    .rec_pop_o   (rec_pop),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .clk_res_o   (clk_res_o),
    .mosi_o      (mosi_o),
    .reply_byte_o(reply_byte_o),
    .last_o      (last_o)
  );

endmodule

// ===== rtl/swtb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI word transfer bridge checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module swtb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       kind_o,
  input logic       clk_res_o,
  input logic       mosi_o,
  input logic [7:0] reply_byte_o,
  input logic       last_o
);

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before transfer");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable({kind_o, clk_res_o, mosi_o, reply_byte_o, last_o}))
    else $error("stalled result changed");

  a_pin_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !kind_o |-> reply_byte_o == 8'd0)
    else $error("pin result carries a reply byte");

  a_reply_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o |-> clk_res_o && mosi_o)
    else $error("reply byte while serial lines not idle");

  a_reply_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !last_o |=> !empty && kind_o)
    else $error("reply byte missing after non-final result");

endmodule

bind spi_word_transfer_bridge swtb_checker u_swtb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .kind_o      (kind_o),
  .clk_res_o   (clk_res_o),
  .mosi_o      (mosi_o),
  .reply_byte_o(reply_byte_o),
  .last_o      (last_o)
);
